// File: rtl/core/psjs_pkg.sv
// Shared types, defaults and control bundles of the shortest-job scheduler.
package psjs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  typedef enum logic [0:0] {
    OP_ARRIVE   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] job_id;
    logic [31:0] job_length;
    logic [31:0] job_left;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        done_valid;
    logic [15:0] done_id;
    logic        cancel_pending;
    logic        sched_valid;
    logic [31:0] sched_time;
    logic        full_error;
    logic        busy_res;
    logic [15:0] running_id;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
    logic wrback;
    logic push;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
    logic preempt;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/psjs_ctrl.sv
// Sequencing state machine of the shortest-job scheduler.
module psjs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  psjs_pkg::dp_sts_t sts,
  output psjs_pkg::dp_cmd_t cmd
);
  import psjs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_FINISH = 6'b001000,
    S_WRBACK = 6'b010000,
    S_PUSH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = sts.preempt ? S_WRBACK : S_PUSH;
      S_WRBACK: state_nxt = S_PUSH;
      S_PUSH:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.start  = (state_r == S_IDLE) && in_valid;
  assign cmd.issue  = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_FINISH);
  assign cmd.wrback = (state_r == S_WRBACK);
  assign cmd.push   = (state_r == S_PUSH) && sts.out_free;

endmodule

// File: rtl/core/psjs_dp.sv
// Job store, slot scan, running-job registers and result register.
module psjs_dp #(
  parameter int QUEUE_DEPTH = psjs_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = psjs_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psjs_pkg::in_item_t  in_data,
  input  psjs_pkg::dp_cmd_t   cmd,
  output psjs_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output psjs_pkg::out_item_t out_data
);
  import psjs_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int TB = TIME_BITS;

  typedef struct packed {
    logic [TB-1:0] len;
    logic [15:0]   id;
    logic [TB-1:0] left;
  } ent_t;

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? {TB{1'b1}} : s[TB-1:0];
  endfunction

  // Job store.
  ent_t mem [QUEUE_DEPTH];
  ent_t rd_r;
  logic mem_we;
  logic [IW-1:0] mem_wa;
  ent_t mem_wd;

  // Latched item.
  op_t           op_r;
  logic [15:0]   id_r;
  logic [TB-1:0] len_r, left_r, now_r;

  // Scan pipeline.
  logic [IW-1:0]          idx_r;
  logic                   stg_v_r, stg_used_r;
  logic [IW-1:0]          stg_idx_r;
  logic [QUEUE_DEPTH-1:0] used_r;
  logic                   free_v_r, best_v_r;
  logic [IW-1:0]          free_idx_r, best_idx_r;
  ent_t                   best_r;

  // Running job.
  logic          run_v_r;
  logic [IW-1:0] run_slot_r;
  logic [15:0]   run_id_r;
  logic [TB-1:0] run_len_r, run_left_r, run_start_r;

  // Deferred write of the preempted job's remaining time.
  logic [IW-1:0] wb_addr_r;
  ent_t          wb_ent_r;

  out_item_t res_r, res_nxt;
  out_item_t out_r;
  logic      out_v_r;

  logic          arrive, preempt;
  logic [TB-1:0] elapsed, new_left, sched;

  assign arrive  = (op_r == OP_ARRIVE);
  assign preempt = arrive && free_v_r && run_v_r && (len_r < run_len_r);
  assign elapsed = (now_r >= run_start_r) ? now_r - run_start_r : '0;
  assign new_left = (elapsed >= run_left_r) ? '0 : run_left_r - elapsed;
  assign sched   = sat_add(now_r, arrive ? left_r : best_r.left);

  assign sts.scan_last = (idx_r == IW'(QUEUE_DEPTH - 1));
  assign sts.preempt   = preempt;
  assign sts.out_free  = !out_v_r || out_ready;

  // Result of the item, with the running state it leaves behind.
  always_comb begin
    res_nxt = '0;
    res_nxt.busy_res   = run_v_r;
    res_nxt.running_id = run_id_r;
    if (arrive) begin
      if (!free_v_r) begin
        res_nxt.full_error = 1'b1;
      end else if (!run_v_r || preempt) begin
        res_nxt.cancel_pending = preempt;
        res_nxt.sched_valid    = 1'b1;
        res_nxt.sched_time     = 32'(sched);
        res_nxt.busy_res       = 1'b1;
        res_nxt.running_id     = id_r;
      end
    end else if (run_v_r) begin
      res_nxt.done_valid = 1'b1;
      res_nxt.done_id    = run_id_r;
      if (best_v_r) begin
        res_nxt.sched_valid = 1'b1;
        res_nxt.sched_time  = 32'(sched);
        res_nxt.running_id  = best_r.id;
      end else begin
        res_nxt.busy_res   = 1'b0;
        res_nxt.running_id = '0;
      end
    end
    if (!res_nxt.busy_res) res_nxt.running_id = '0;
  end

  assign mem_we = (cmd.finish && arrive && free_v_r) || cmd.wrback;
  assign mem_wa = cmd.wrback ? wb_addr_r : free_idx_r;
  assign mem_wd = cmd.wrback ? wb_ent_r : ent_t'{len: len_r, id: id_r, left: left_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.issue) rd_r <= mem[idx_r];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= op_t'(in_data.opcode);
      id_r   <= in_data.job_id;
      len_r  <= TB'(in_data.job_length);
      left_r <= TB'(in_data.job_left);
      now_r  <= TB'(in_data.now);
    end
    if (cmd.issue) begin
      stg_used_r <= used_r[idx_r];
      stg_idx_r  <= idx_r;
    end
    if (stg_v_r) begin
      if (!stg_used_r && !free_v_r) free_idx_r <= stg_idx_r;
      if (stg_used_r && (!best_v_r || {rd_r.len, rd_r.id} < {best_r.len, best_r.id})) begin
        best_idx_r <= stg_idx_r;
        best_r     <= rd_r;
      end
    end
    if (cmd.finish) begin
      res_r     <= res_nxt;
      wb_addr_r <= run_slot_r;
      wb_ent_r  <= ent_t'{len: run_len_r, id: run_id_r, left: new_left};
      if (arrive && free_v_r && (!run_v_r || preempt)) begin
        run_id_r   <= id_r;
        run_len_r  <= len_r;
        run_left_r <= left_r;
      end else if (!arrive && run_v_r && best_v_r) begin
        run_id_r   <= best_r.id;
        run_len_r  <= best_r.len;
        run_left_r <= best_r.left;
      end
    end
    if (cmd.push) out_r <= res_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      stg_v_r     <= 1'b0;
      free_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
      used_r      <= '0;
      run_v_r     <= 1'b0;
      run_slot_r  <= '0;
      run_start_r <= '0;
      out_v_r     <= 1'b0;
    end else begin
      stg_v_r <= cmd.issue;
      if (cmd.start) begin
        idx_r    <= '0;
        free_v_r <= 1'b0;
        best_v_r <= 1'b0;
        // Retire the running job before the scan so it cannot win again.
        if (in_data.opcode == OP_COMPLETE && run_v_r) used_r[run_slot_r] <= 1'b0;
      end
      if (cmd.issue) idx_r <= idx_r + 1'b1;
      if (stg_v_r) begin
        if (!stg_used_r) free_v_r <= 1'b1;
        if (stg_used_r) best_v_r <= 1'b1;
      end
      if (cmd.finish) begin
        if (arrive) begin
          if (free_v_r) begin
            used_r[free_idx_r] <= 1'b1;
            if (!run_v_r || preempt) begin
              run_v_r     <= 1'b1;
              run_slot_r  <= free_idx_r;
              run_start_r <= now_r;
            end
          end
        end else if (run_v_r) begin
          run_start_r <= now_r;
          if (best_v_r) begin
            run_slot_r <= best_idx_r;
          end else begin
            run_v_r <= 1'b0;
          end
        end
      end
      if (cmd.push) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/preemptive_shortest_job_scheduler.sv
// Top level of the preemptive shortest-job-first scheduler.
//
// Each transfer on the input channel is one event: an arrival (job id, total
// length, remaining time, current time) or the completion of the running job.
// Every event yields exactly one result transfer. Arrivals are kept in a
// QUEUE_DEPTH-entry job store ranked by total length, then id, then slot index.
// A strictly shorter arrival preempts the running job, whose remaining time is
// reduced by the time it ran; a completion retires the running job and starts
// the best stored one. Time values are TIME_BITS wide and saturate. Each event
// is handled by a scan that reads the job store one slot per cycle through its
// single read port to find a free slot or the smallest key, and a preemption
// adds a write-back step for the preempted job before the result is ready. One
// event is in work at a time; the result register lets the next event enter
// while a result still waits for its transfer.
module preemptive_shortest_job_scheduler #(
  parameter int QUEUE_DEPTH = psjs_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = psjs_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psjs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psjs_pkg::out_item_t out_data
);
  import psjs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each event: accept, scan the store, settle, write back, deliver.
  psjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the job store, running-job state and the result register.
  psjs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
